// ===== rtl/e2fat_pkg.sv =====
// Package: constants and lookup function for the epoch to FAT stamp converter.
`timescale 1ns / 1ps
package e2fat_pkg;

  localparam int NUM_STAGES = 10;

  // register map, one register: index taken from paddr[2]
  localparam int  PADDR_W       = 3;
  localparam logic REG_TZ_OFFSET = 1'b0;

  localparam logic signed [10:0] TZ_MIN = -11'sd720;
  localparam logic signed [10:0] TZ_MAX = 11'sd840;

  localparam logic signed [33:0] MIN_VALID_EPOCH = 34'sd1577836800;

  // 2024-01-01
  localparam logic [15:0] FALLBACK_DATE = 16'((2024 - 1980) << 9 | 1 << 5 | 1);

  // floor(n/d) = (n * RECIP) >> SHIFT over the stated input width
  localparam logic [26:0] DAY_RECIP   = 27'd101806633;  // /675, n < 2^26
  localparam int          DAY_SHIFT   = 36;
  localparam logic [14:0] Y4_RECIP    = 15'd22983;      // /365, n < 2^14 (doe/1460)
  localparam int          Y4_SHIFT    = 23;
  localparam logic [16:0] YEAR_RECIP  = 17'd91930;      // /365, n < 2^16
  localparam int          YEAR_SHIFT  = 25;
  localparam logic [13:0] HOUR_RECIP  = 14'd9321;       // /225, n < 2^13 (secs/3600)
  localparam int          HOUR_SHIFT  = 21;
  localparam logic [10:0] MIN_RECIP   = 11'd1093;       // /15, n < 2^10 (secs/60)
  localparam int          MIN_SHIFT   = 14;
  localparam logic [11:0] MP_RECIP    = 12'd3427;       // /153, n < 2^11
  localparam int          MP_SHIFT    = 19;

  // days from 1970-01-01 to 2000-03-01, start of the fixed 400-year era
  localparam logic [15:0] ERA_OFFSET  = 16'd11017;
  localparam logic [15:0] CENTURY_DOE = 16'd36524;

  // (153*mp + 2) / 5 for the March-based month index
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/epoch_to_fat_timestamp_top.sv =====
// Top level: Unix epoch seconds to FAT date/time stamp, pipelined.
`timescale 1ns / 1ps
// One request enters per clock and one stamp is presented per clock while stamp_stall is
// low. Ten register stages: timezone add, then constant reciprocal multiplies (days,
// era quarter, year of era, month, hour, minute), each but the era quarter with its
// back-multiply in the following stage, then the pack into FAT fields.
// epoch_stall pulls back only as far as the pipeline is actually full, so bubbles are
// squeezed out while stamp_stall is high. The timezone offset register (byte address
// 0) is clamped to -720..840 minutes on write; change it only while the pipeline is
// empty. Adjusted times before 2020-01-01 give 2024-01-01 00:00:00 with used_fallback.
module epoch_to_fat_timestamp_top (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [e2fat_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // epoch requests
  input  logic                             epoch_valid,
  output logic                             epoch_stall,
  input  logic [31:0]                      epoch_seconds,
  // stamps
  output logic                             stamp_valid,
  input  logic                             stamp_stall,
  output logic [15:0]                      stamp_date,
  output logic [15:0]                      stamp_time,
  output logic                             used_fallback
);
  import e2fat_pkg::*;

  logic signed [10:0] timezone_offset_minutes;
  logic signed [10:0] wr_value;
  logic               cfg_write;

  logic [NUM_STAGES:1] vld;
  logic [NUM_STAGES:1] rdy;

  // ---------------- configuration ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TZ_OFFSET);
  assign wr_value  = signed'(pwdata[10:0]);
  assign prdata    = (paddr[2] == REG_TZ_OFFSET) ?
                     {{21{timezone_offset_minutes[10]}}, timezone_offset_minutes} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timezone_offset_minutes <= '0;
    end else if (cfg_write) begin
      if (wr_value < TZ_MIN) begin
        timezone_offset_minutes <= TZ_MIN;
      end else if (wr_value > TZ_MAX) begin
        timezone_offset_minutes <= TZ_MAX;
      end else begin
        timezone_offset_minutes <= wr_value;
      end
    end
  end

  // ---------------- flow control ----------------
  always_comb begin
    rdy[NUM_STAGES] = !vld[NUM_STAGES] || !stamp_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign epoch_stall = !rdy[1];
  assign stamp_valid = vld[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= epoch_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------- stage 1: timezone adjust ----------------
  logic signed [16:0] tz_ext;
  logic signed [16:0] tz_secs;
  logic signed [33:0] adj_c;
  logic signed [33:0] s1_adj;

  assign tz_ext  = {{6{timezone_offset_minutes[10]}}, timezone_offset_minutes};
  assign tz_secs = (tz_ext <<< 6) - (tz_ext <<< 2);
  assign adj_c   = signed'({2'b00, epoch_seconds}) + {{17{tz_secs[16]}}, tz_secs};

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_adj <= adj_c;
    end
  end

  // ---------------- stage 2: fallback test, day reciprocal ----------------
  logic [25:0] s1_n;
  logic [52:0] s2_prod;
  logic [25:0] s2_n;
  logic [6:0]  s2_t7;
  logic        s2_fb;

  assign s1_n = s1_adj[32:7];   // t/86400 = (t>>7)/675

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_fb   <= (s1_adj < MIN_VALID_EPOCH);
      s2_prod <= 53'(s1_n) * 53'(DAY_RECIP);
      s2_n    <= s1_n;
      s2_t7   <= s1_adj[6:0];
    end
  end

  // ---------------- stage 3: days and remainder ----------------
  logic [15:0] days_c;
  logic [25:0] day_back;
  logic [25:0] day_rem;
  logic [15:0] s3_days;
  logic [9:0]  s3_rem;
  logic [6:0]  s3_t7;
  logic        s3_fb;

  assign days_c   = s2_prod[DAY_SHIFT+15:DAY_SHIFT];
  assign day_back = 26'(days_c) * 26'd675;
  assign day_rem  = s2_n - day_back;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_fb   <= s2_fb;
      s3_days <= days_c;
      s3_rem  <= day_rem[9:0];
      s3_t7   <= s2_t7;
    end
  end

  // ---------------- stage 4: day of era, second of day ----------------
  logic [15:0] s4_doe;
  logic [16:0] s4_secs;
  logic        s4_fb;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_fb   <= s3_fb;
      s4_doe  <= s3_days - ERA_OFFSET;
      s4_secs <= {s3_rem, s3_t7};
    end
  end

  // ---------------- stage 5: doe/1460, doe/36524, hour ----------------
  logic [28:0] y4_prod;
  logic [26:0] hour_prod;
  logic [15:0] s5_doe;
  logic [4:0]  s5_q4;
  logic        s5_cent;
  logic [4:0]  s5_hour;
  logic [16:0] s5_secs;
  logic        s5_fb;

  assign y4_prod   = 29'(s4_doe[15:2]) * 29'(Y4_RECIP);
  assign hour_prod = 27'(s4_secs[16:4]) * 27'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_fb   <= s4_fb;
      s5_doe  <= s4_doe;
      s5_q4   <= y4_prod[Y4_SHIFT+4:Y4_SHIFT];
      s5_cent <= (s4_doe >= CENTURY_DOE);
      s5_hour <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
      s5_secs <= s4_secs;
    end
  end

  // ---------------- stage 6: year numerator, second of hour ----------------
  logic [16:0] hour_back;
  logic [16:0] hour_rem;
  logic [15:0] s6_doe;
  logic [15:0] s6_num;
  logic [4:0]  s6_hour;
  logic [11:0] s6_rs;
  logic        s6_fb;

  assign hour_back = 17'(s5_hour) * 17'd3600;
  assign hour_rem  = s5_secs - hour_back;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_fb   <= s5_fb;
      s6_doe  <= s5_doe;
      s6_num  <= s5_doe - 16'(s5_q4) + 16'(s5_cent);
      s6_hour <= s5_hour;
      s6_rs   <= hour_rem[11:0];
    end
  end

  // ---------------- stage 7: year of era, minute ----------------
  logic [32:0] yoe_prod;
  logic [20:0] min_prod;
  logic [15:0] s7_doe;
  logic [6:0]  s7_yoe;
  logic [4:0]  s7_hour;
  logic [5:0]  s7_min;
  logic [11:0] s7_rs;
  logic        s7_fb;

  assign yoe_prod = 33'(s6_num) * 33'(YEAR_RECIP);
  assign min_prod = 21'(s6_rs[11:2]) * 21'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_fb   <= s6_fb;
      s7_doe  <= s6_doe;
      s7_yoe  <= yoe_prod[YEAR_SHIFT+6:YEAR_SHIFT];
      s7_hour <= s6_hour;
      s7_min  <= min_prod[MIN_SHIFT+5:MIN_SHIFT];
      s7_rs   <= s6_rs;
    end
  end

  // ---------------- stage 8: day of year, seconds/2 ----------------
  logic [15:0] year_days;
  logic [15:0] doy_c;
  logic [11:0] min_back;
  logic [11:0] sec_c;
  logic [8:0]  s8_doy;
  logic [6:0]  s8_yoe;
  logic [4:0]  s8_hour;
  logic [5:0]  s8_min;
  logic [4:0]  s8_sec2;
  logic        s8_fb;

  assign year_days = 16'(s7_yoe) * 16'd365 + 16'(s7_yoe[6:2]) - 16'(s7_yoe >= 7'd100);
  assign doy_c     = s7_doe - year_days;
  assign min_back  = 12'(s7_min) * 12'd60;
  assign sec_c     = s7_rs - min_back;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_fb   <= s7_fb;
      s8_doy  <= doy_c[8:0];
      s8_yoe  <= s7_yoe;
      s8_hour <= s7_hour;
      s8_min  <= s7_min;
      s8_sec2 <= sec_c[5:1];
    end
  end

  // ---------------- stage 9: March-based month ----------------
  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic [8:0]  s9_doy;
  logic [3:0]  s9_mp;
  logic [6:0]  s9_yoe;
  logic [15:0] s9_time;
  logic        s9_fb;

  assign mp_num  = {s8_doy, 2'b00} + 11'(s8_doy) + 11'd2;
  assign mp_prod = 23'(mp_num) * 23'(MP_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_fb   <= s8_fb;
      s9_doy  <= s8_doy;
      s9_mp   <= mp_prod[MP_SHIFT+3:MP_SHIFT];
      s9_yoe  <= s8_yoe;
      s9_time <= {s8_hour, s8_min, s8_sec2};
    end
  end

  // ---------------- stage 10: pack ----------------
  logic [8:0] day_c;
  logic [3:0] month_c;
  logic       jan_feb;
  logic [6:0] year_c;

  // January and February belong to the following calendar year
  assign jan_feb = (s9_mp >= 4'd10);
  assign day_c   = s9_doy - month_start(s9_mp) + 9'd1;
  assign month_c = jan_feb ? s9_mp - 4'd9 : s9_mp + 4'd3;
  // years count from 2000 here, always above the 1980 floor
  assign year_c  = s9_yoe + 7'd20 + 7'(jan_feb);

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      used_fallback <= s9_fb;
      stamp_date    <= s9_fb ? FALLBACK_DATE : {year_c, month_c, day_c[4:0]};
      stamp_time    <= s9_fb ? 16'd0 : s9_time;
    end
  end

  // ---------------- assertions ----------------
  a_tz_range: assert property (@(posedge clk) disable iff (rst)
    timezone_offset_minutes >= TZ_MIN && timezone_offset_minutes <= TZ_MAX)
    else $error("timezone offset outside clamp range");

  a_fallback_stamp: assert property (@(posedge clk) disable iff (rst)
    stamp_valid && used_fallback |-> stamp_date == FALLBACK_DATE && stamp_time == 16'd0)
    else $error("fallback request without fallback stamp");

  a_date_fields: assert property (@(posedge clk) disable iff (rst)
    stamp_valid && !used_fallback |->
      stamp_date[8:5] >= 4'd1 && stamp_date[8:5] <= 4'd12 &&
      stamp_date[4:0] >= 5'd1 && stamp_date[15:9] >= 7'd40)
    else $error("calendar date out of range");

  a_time_fields: assert property (@(posedge clk) disable iff (rst)
    stamp_valid |-> stamp_time[15:11] <= 5'd23 && stamp_time[10:5] <= 6'd59 &&
      stamp_time[4:0] <= 5'd29)
    else $error("time of day out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !stamp_valid)
    else $error("stamp valid straight after reset");

endmodule
